// ===== src/packed_glyph_row_unpacker_macros.svh =====
// Assertion macros for the packed glyph row unpacker checker.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef PACKED_GLYPH_ROW_UNPACKER_MACROS_SVH
`define PACKED_GLYPH_ROW_UNPACKER_MACROS_SVH

// Checked only out of reset.
`define PGRU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PGRU_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/pgru_pkg.sv =====
// Types, constants and helpers shared by the glyph row unpacker.
// No dependencies.
package pgru_pkg;

  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned OutTdataW = 40;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [CfgAddrW-1:0] REG_GLYPH_WIDTH = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_GLYPH_ROWS  = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_TOP_OFFSET  = 2'd2;

  localparam logic [3:0] WIDTH_RESET  = 4'd8;
  localparam logic [7:0] ROWS_RESET   = 8'd8;
  localparam logic [3:0] OFFSET_RESET = 4'd0;

  // packing mode limits on glyph width
  localparam logic [3:0] NARROW_MAX = 4'd4;
  localparam logic [3:0] MEDIUM_MAX = 4'd8;

  typedef struct packed {
    logic [3:0] glyph_width;
    logic [7:0] glyph_rows;
    logic [3:0] top_offset;
  } glyph_cfg_t;

  typedef struct packed {
    logic [15:0] row_bits;
    logic [8:0]  row_index;
    logic        last_row;
    logic [8:0]  inked_height;
  } row_result_t;

  typedef struct packed {
    logic [1:0]  count;
    row_result_t row0;
    row_result_t row1;
  } unpack_out_t;

  // top w bits set, pixel 0 at bit 15
  function automatic logic [15:0] width_mask(input logic [3:0] w);
    width_mask = ~(16'hFFFF >> w);
  endfunction

endpackage

// ===== src/pgru_row_unpack.sv =====
// Per-glyph state and the row decode for one packed byte.
// Depends on pgru_pkg.
module pgru_row_unpack (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [7:0]            src_byte,
  input  pgru_pkg::glyph_cfg_t  cfg,
  output pgru_pkg::unpack_out_t result
);
  import pgru_pkg::*;

  logic [7:0] rows_done_r, rows_done_nxt;
  logic [6:0] first_half_r, first_half_nxt;
  logic       awaiting_r, awaiting_nxt;
  logic [8:0] tallest_r, tallest_nxt;

  logic [15:0] mask;
  logic        is_wide;
  logic        is_narrow;
  logic [15:0] bits0;
  logic [15:0] bits1;
  logic [8:0]  idx0;
  logic [8:0]  idx1;
  logic [8:0]  tall0;
  logic [8:0]  tall1;
  logic [7:0]  done1;
  logic        last0;
  logic        last1;

  always_comb begin
    mask      = width_mask(cfg.glyph_width);
    is_wide   = cfg.glyph_width > MEDIUM_MAX;
    is_narrow = cfg.glyph_width <= NARROW_MAX;

    if (is_wide) begin
      bits0 = {first_half_r, src_byte, 1'b0} & mask;
    end else begin
      bits0 = {src_byte, 8'h00} & mask;
    end
    bits1 = {src_byte[3:0], 12'h000} & mask;

    idx0  = {5'd0, cfg.top_offset} + {1'b0, rows_done_r};
    last0 = ({1'b0, rows_done_r} + 9'd1) >= {1'b0, cfg.glyph_rows};
    tall0 = (bits0 != 16'h0000) ? idx0 + 9'd1 : tallest_r;

    done1 = rows_done_r + 8'd1;
    idx1  = {5'd0, cfg.top_offset} + {1'b0, done1};
    last1 = ({1'b0, done1} + 9'd1) >= {1'b0, cfg.glyph_rows};
    tall1 = (bits1 != 16'h0000) ? idx1 + 9'd1 : tall0;
  end

  always_comb begin
    if (is_wide) begin
      result.count = awaiting_r ? 2'd1 : 2'd0;
    end else if (is_narrow) begin
      result.count = last0 ? 2'd1 : 2'd2;
    end else begin
      result.count = 2'd1;
    end

    result.row0.row_bits     = bits0;
    result.row0.row_index    = idx0;
    result.row0.last_row     = last0;
    result.row0.inked_height = last0 ? ((tall0 == 9'd0) ? 9'd1 : tall0) : 9'd0;

    result.row1.row_bits     = bits1;
    result.row1.row_index    = idx1;
    result.row1.last_row     = last1;
    result.row1.inked_height = last1 ? ((tall1 == 9'd0) ? 9'd1 : tall1) : 9'd0;
  end

  always_comb begin
    rows_done_nxt  = rows_done_r;
    first_half_nxt = first_half_r;
    awaiting_nxt   = awaiting_r;
    tallest_nxt    = tallest_r;
    if (go) begin
      if (is_wide && !awaiting_r) begin
        first_half_nxt = src_byte[6:0];
        awaiting_nxt   = 1'b1;
      end else begin
        first_half_nxt = 7'd0;
        awaiting_nxt   = 1'b0;
        if (last0 || (is_narrow && last1)) begin
          // glyph ends here
          rows_done_nxt = 8'd0;
          tallest_nxt   = 9'd0;
        end else if (is_narrow) begin
          rows_done_nxt = done1 + 8'd1;
          tallest_nxt   = tall1;
        end else begin
          rows_done_nxt = done1;
          tallest_nxt   = tall0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_done_r  <= 8'd0;
      first_half_r <= 7'd0;
      awaiting_r   <= 1'b0;
      tallest_r    <= 9'd0;
    end else begin
      rows_done_r  <= rows_done_nxt;
      first_half_r <= first_half_nxt;
      awaiting_r   <= awaiting_nxt;
      tallest_r    <= tallest_nxt;
    end
  end

endmodule

// ===== src/pgru_result_fifo.sv =====
// Result register queue: takes up to two rows per cycle, gives one while out_ready is high.
// Depends on pgru_pkg.
module pgru_result_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  pgru_pkg::unpack_out_t wr,
  output logic                  space_ok,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pgru_pkg::row_result_t out_row
);
  import pgru_pkg::*;

  row_result_t         mem_r [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FifoPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FifoCntW-1:0] cnt_r, cnt_nxt;
  logic [1:0]          push_n;
  logic                pop;

  always_comb begin
    push_n     = push ? wr.count : 2'd0;
    pop        = out_valid && out_ready;
    wr_ptr_nxt = wr_ptr_r + FifoPtrW'(push_n);
    rd_ptr_nxt = rd_ptr_r + FifoPtrW'(pop);
    cnt_nxt    = cnt_r + FifoCntW'(push_n) - FifoCntW'(pop);
  end

  assign space_ok  = cnt_r <= FifoCntW'(FifoDepth - 2);
  assign out_valid = cnt_r != '0;
  assign out_row   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= wr.row0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_r + FifoPtrW'(1)] <= wr.row1;
    end
  end

endmodule

// ===== src/packed_glyph_row_unpacker.sv =====
// Packed glyph row unpacker, top level: config registers, input register,
// row decode and a four-entry result queue. Depends on pgru_pkg.
// An accepted byte is held in the input register, and its rows in the result queue, before output.
// Throughput: one byte per cycle for widths 5 to 15 while the output is not stalled;
// narrow glyphs give up to two rows per byte, so the single output port holds their bytes back.
// Reset (rst_n low, synchronous): queue emptied, glyph state cleared, config defaults.
module packed_glyph_row_unpacker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] src_byte
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] row_bits, [24:16] row_index, [33:25] inked_height, [39:34] zero
  output logic [pgru_pkg::OutTdataW-1:0]     out_tdata,
  output logic                               out_tlast,  // last_row
  input  logic                               cfg_we,
  input  logic [pgru_pkg::CfgAddrW-1:0]      cfg_addr,
  input  logic [pgru_pkg::CfgDataW-1:0]      cfg_wdata
);
  import pgru_pkg::*;

  glyph_cfg_t  cfg_r, cfg_nxt;
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        go;
  logic        space_ok;
  unpack_out_t unpacked;
  row_result_t out_row;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_GLYPH_WIDTH: cfg_nxt.glyph_width = cfg_wdata[3:0];
        REG_GLYPH_ROWS:  cfg_nxt.glyph_rows  = cfg_wdata[7:0];
        REG_TOP_OFFSET:  cfg_nxt.top_offset  = cfg_wdata[3:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.glyph_width <= WIDTH_RESET;
      cfg_r.glyph_rows  <= ROWS_RESET;
      cfg_r.top_offset  <= OFFSET_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign go        = in_valid_r && space_ok;
  assign in_tready = !in_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  pgru_row_unpack u_row_unpack (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .src_byte (in_byte_r),
    .cfg      (cfg_r),
    .result   (unpacked)
  );

  pgru_result_fifo u_result_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (go),
    .wr        (unpacked),
    .space_ok  (space_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_row   (out_row)
  );

  assign out_tdata = {6'd0, out_row.inked_height, out_row.row_index, out_row.row_bits};
  assign out_tlast = out_row.last_row;

endmodule

// ===== src/pgru_checker.sv =====
// Port-level checks for the packed glyph row unpacker, bound to the top level.
// Depends on packed_glyph_row_unpacker_macros.svh.
`include "packed_glyph_row_unpacker_macros.svh"

module pgru_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  `PGRU_ASSERT_RST(a_reset_empties, !rst_n |=> !out_tvalid, "output valid right after reset")
  `PGRU_ASSERT(a_valid_holds, out_tvalid && !out_tready |=> out_tvalid, "stalled request dropped")
  `PGRU_ASSERT(a_height_on_last, out_tvalid && out_tlast |-> out_tdata[33:25] != 9'd0, "zero height on last row")
  `PGRU_ASSERT(a_height_only_last, out_tvalid && !out_tlast |-> out_tdata[33:25] == 9'd0, "height before last row")

endmodule

bind packed_glyph_row_unpacker pgru_checker u_pgru_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
